### rtl/rirs_pkg.sv
// Shared types and constants for the range increment / range sum block.
// No dependencies.
package rirs_pkg;

  localparam int POSITIONS_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 32;
  localparam int POS_W          = 12;
  localparam int SUM_W          = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic CMD_INC   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // frame phase: which child is visited next
  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_QACC,
    ST_RET, ST_POPPED, ST_FREAD, ST_FWRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic eval;
    logic qmul;
    logic qacc;
    logic push;
    logic pop;
    logic psum_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       in_empty;
    logic       in_query;
    logic       is_query;
    logic       disjoint;
    logic       full;
    logic       sp_zero;
    logic       res_free;
    logic [1:0] phase;
  } dp_status_t;

endpackage

### rtl/rirs_if.sv
// Handshake interfaces for the command and result channels.
// Depends on rirs_pkg.
interface rirs_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [rirs_pkg::POS_W-1:0] low_pos;
  logic [rirs_pkg::POS_W-1:0] high_pos;
  modport source(output valid, command, low_pos, high_pos, input ready);
  modport sink(input valid, command, low_pos, high_pos, output ready);
endinterface

interface rirs_res_if;
  logic                       valid;
  logic                       ready;
  logic [rirs_pkg::SUM_W-1:0] range_total;
  modport source(output valid, range_total, input ready);
  modport sink(input valid, range_total, output ready);
endinterface

### rtl/range_increment_range_sum_top.sv
// Top level of the range increment / range sum block.
// Depends on rirs_pkg, rirs_if, rirs_ctrl and rirs_datapath.
//
// cmd carries items of {command, low_pos, high_pos}: command 0 adds one to
// every card in [low_pos, high_pos], command 1 asks for the sum of the
// counts over that range; low above high means an empty range. res carries
// one range_total item per query, saturating at 2^48-1.
// After reset a clearing pass writes every tree node (4*POSITIONS of them)
// to zero, one node a cycle; cmd.ready stays low then.
// Items are handled one at a time. The walk visits each node in steps
// (memory read, evaluate, multiply/accumulate for a query, return, and a
// read-modify-write of the partial sum on the way up for an increment);
// an empty increment is taken without a walk, an empty query goes
// straight to the result register, and otherwise the walk over the node
// memory sets the rate.
// A finished query result sits in an output register; while the receiver
// stalls the next item is still taken and walked, and only the next query
// result waits for the register to free.
module range_increment_range_sum_top #(
  parameter int POSITIONS  = rirs_pkg::POSITIONS_DEF,
  parameter int COUNT_BITS = rirs_pkg::COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  rirs_cmd_if.sink   cmd,
  rirs_res_if.source res
);

  rirs_pkg::dp_cmd_t    dp_cmd;
  rirs_pkg::dp_status_t dp_status;
  logic                 in_ready;

  assign cmd.ready = in_ready;

  rirs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  rirs_datapath #(
    .POSITIONS  (POSITIONS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .command     (cmd.command),
    .low_pos     (cmd.low_pos),
    .high_pos    (cmd.high_pos),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .range_total (res.range_total)
  );

endmodule

### rtl/rirs_ctrl.sv
// Sequencer for the tree walk: clearing pass, node visits, returns.
// Depends on rirs_pkg.
module rirs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rirs_pkg::dp_status_t status,
  output rirs_pkg::dp_cmd_t    cmd
);

  rirs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rirs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      rirs_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) state_next = rirs_pkg::ST_IDLE;
      end
      rirs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_empty) begin
            state_next = status.in_query ? rirs_pkg::ST_OUT : rirs_pkg::ST_IDLE;
          end else begin
            state_next = rirs_pkg::ST_READ;
          end
        end
      end
      rirs_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = rirs_pkg::ST_EVAL;
      end
      rirs_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.disjoint) begin
          state_next = rirs_pkg::ST_RET;
        end else if (status.is_query) begin
          cmd.qmul   = 1'b1;
          state_next = rirs_pkg::ST_QACC;
        end else if (status.full) begin
          state_next = rirs_pkg::ST_RET;
        end else begin
          cmd.push   = 1'b1;
          state_next = rirs_pkg::ST_READ;
        end
      end
      rirs_pkg::ST_QACC: begin
        cmd.qacc = 1'b1;
        if (status.full) begin
          state_next = rirs_pkg::ST_RET;
        end else begin
          cmd.push   = 1'b1;
          state_next = rirs_pkg::ST_READ;
        end
      end
      rirs_pkg::ST_RET: begin
        if (status.sp_zero) begin
          state_next = status.is_query ? rirs_pkg::ST_OUT : rirs_pkg::ST_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = rirs_pkg::ST_POPPED;
        end
      end
      rirs_pkg::ST_POPPED: begin
        case (status.phase)
          rirs_pkg::PH_RIGHT: begin
            cmd.push   = 1'b1;
            state_next = rirs_pkg::ST_READ;
          end
          rirs_pkg::PH_DONE: begin
            state_next = status.is_query ? rirs_pkg::ST_RET : rirs_pkg::ST_FREAD;
          end
          default: state_next = rirs_pkg::ST_RET;
        endcase
      end
      rirs_pkg::ST_FREAD: begin
        cmd.rd     = 1'b1;
        state_next = rirs_pkg::ST_FWRITE;
      end
      rirs_pkg::ST_FWRITE: begin
        cmd.psum_wr = 1'b1;
        state_next  = rirs_pkg::ST_RET;
      end
      rirs_pkg::ST_OUT: begin
        if (status.res_free) begin
          cmd.out_load = 1'b1;
          state_next   = rirs_pkg::ST_IDLE;
        end
      end
      default: state_next = rirs_pkg::ST_CLEAR;
    endcase
  end

endmodule

### rtl/rirs_datapath.sv
// Tree memories, walk stack, multiply/accumulate and result register.
// Depends on rirs_pkg.
module rirs_datapath #(
  parameter int POSITIONS  = rirs_pkg::POSITIONS_DEF,
  parameter int COUNT_BITS = rirs_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rirs_pkg::dp_cmd_t          cmd,
  output rirs_pkg::dp_status_t       status,
  input  logic                       command,
  input  logic [rirs_pkg::POS_W-1:0] low_pos,
  input  logic [rirs_pkg::POS_W-1:0] high_pos,
  input  logic                       res_ready,
  output logic                       res_valid,
  output logic [rirs_pkg::SUM_W-1:0] range_total
);

  localparam int SW    = rirs_pkg::SUM_W;
  localparam int NODES = 4 * POSITIONS;
  localparam int NB    = $clog2(NODES);
  localparam int PB    = $clog2(POSITIONS);
  localparam int CW    = (PB > rirs_pkg::POS_W) ? PB : rirs_pkg::POS_W;
  localparam int SPW   = $clog2(POSITIONS + 1);
  localparam int DEPTH = PB + 1;
  localparam int SPB   = $clog2(DEPTH);
  localparam int PW    = COUNT_BITS + SPW;
  localparam int EW    = (PW > SW) ? PW : SW;
  localparam logic [CW-1:0] LAST = CW'(POSITIONS - 1);

  logic [CW-1:0] a_ext, b_ext, b_clamp, qa, qb;
  logic          is_query;

  assign a_ext   = CW'(low_pos);
  assign b_ext   = CW'(high_pos);
  assign b_clamp = (b_ext > LAST) ? LAST : b_ext;

  // walk stack, one frame per tree level
  logic [NB-1:0]  stk_k   [DEPTH];
  logic [CW-1:0]  stk_lo  [DEPTH];
  logic [CW-1:0]  stk_hi  [DEPTH];
  logic [1:0]     stk_ph  [DEPTH];
  logic [SPW-1:0] stk_acc [DEPTH];
  logic [SPB-1:0] sp;

  logic [NB-1:0]  top_k;
  logic [CW-1:0]  top_lo, top_hi, mid, ov_l, ov_r;
  logic [1:0]     top_ph;
  logic [SPW-1:0] top_acc, span, overlap, ret_val;
  logic           disjoint, full;

  assign top_k   = stk_k[sp];
  assign top_lo  = stk_lo[sp];
  assign top_hi  = stk_hi[sp];
  assign top_ph  = stk_ph[sp];
  assign top_acc = stk_acc[sp];
  assign mid     = top_lo + ((top_hi - top_lo) >> 1);
  assign span    = SPW'(top_hi - top_lo) + SPW'(1);
  assign ov_l    = (qa > top_lo) ? qa : top_lo;
  assign ov_r    = (qb < top_hi) ? qb : top_hi;
  assign overlap = SPW'(ov_r - ov_l) + SPW'(1);
  assign disjoint = (qb < top_lo) || (top_hi < qa);
  assign full     = (qa <= top_lo) && (top_hi <= qb);

  // node memories
  logic [COUNT_BITS-1:0] cover_mem [NODES];
  logic [SW-1:0]         psum_mem  [NODES];
  logic [COUNT_BITS-1:0] rd_cover;
  logic [SW-1:0]         rd_psum;
  logic [NB-1:0]         clr_cnt;
  logic                  cover_wr;
  logic [SW:0]           psum_add;
  logic [SW-1:0]         psum_new;

  assign cover_wr = cmd.eval && !is_query && full && !(&rd_cover);
  assign psum_add = {1'b0, rd_psum} + (SW + 1)'(top_acc);
  assign psum_new = psum_add[SW] ? rirs_pkg::SUM_MAX : psum_add[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_cover <= cover_mem[top_k];
      rd_psum  <= psum_mem[top_k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      cover_mem[clr_cnt] <= '0;
    end else if (cover_wr) begin
      cover_mem[top_k] <= rd_cover + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      psum_mem[clr_cnt] <= '0;
    end else if (cmd.psum_wr) begin
      psum_mem[top_k] <= psum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + NB'(1);
    end
  end

  // query multiply and saturating accumulate
  logic [PW-1:0]   prod;
  logic [SW-1:0]   addend, prod_sat, total;
  logic [EW-1:0]   prod_e;
  logic [SW+1:0]   sum3;

  assign prod_e   = EW'(prod);
  assign prod_sat = (prod_e > EW'(rirs_pkg::SUM_MAX)) ? rirs_pkg::SUM_MAX : prod_e[SW-1:0];
  assign sum3     = (SW + 2)'(total) + (SW + 2)'(prod_sat) + (SW + 2)'(addend);

  always_ff @(posedge clk) begin
    if (cmd.qmul) begin
      prod   <= PW'(rd_cover) * PW'(full ? span : overlap);
      addend <= full ? rd_psum : '0;
    end
    if (cmd.load) begin
      qa       <= a_ext;
      qb       <= b_clamp;
      is_query <= command;
      total    <= '0;
    end else if (cmd.qacc) begin
      total <= (sum3 > (SW + 2)'(rirs_pkg::SUM_MAX)) ? rirs_pkg::SUM_MAX : sum3[SW-1:0];
    end
    if (cmd.eval) begin
      ret_val <= cover_wr ? span : '0;
    end else if (cmd.psum_wr) begin
      ret_val <= top_acc;
    end
  end

  // stack frames
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stk_k[0]   <= NB'(1);
      stk_lo[0]  <= '0;
      stk_hi[0]  <= LAST;
      stk_ph[0]  <= rirs_pkg::PH_LEFT;
      stk_acc[0] <= '0;
    end else if (cmd.push) begin
      stk_ph[sp]              <= (top_ph == rirs_pkg::PH_LEFT) ? rirs_pkg::PH_RIGHT
                                                              : rirs_pkg::PH_DONE;
      stk_ph[sp + SPB'(1)]    <= rirs_pkg::PH_LEFT;
      stk_acc[sp + SPB'(1)]   <= '0;
      if (top_ph == rirs_pkg::PH_LEFT) begin
        stk_k[sp + SPB'(1)]  <= {top_k[NB-2:0], 1'b0};
        stk_lo[sp + SPB'(1)] <= top_lo;
        stk_hi[sp + SPB'(1)] <= mid;
      end else begin
        stk_k[sp + SPB'(1)]  <= {top_k[NB-2:0], 1'b1};
        stk_lo[sp + SPB'(1)] <= mid + CW'(1);
        stk_hi[sp + SPB'(1)] <= top_hi;
      end
    end else if (cmd.pop) begin
      stk_acc[sp - SPB'(1)] <= stk_acc[sp - SPB'(1)] + ret_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.load) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + SPB'(1);
    end else if (cmd.pop) begin
      sp <= sp - SPB'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) range_total <= total;
  end

  always_comb begin
    status.clr_done = (clr_cnt == NB'(NODES - 1));
    status.in_empty = (a_ext > b_clamp) || (a_ext > LAST);
    status.in_query = (command == rirs_pkg::CMD_QUERY);
    status.is_query = (is_query == rirs_pkg::CMD_QUERY);
    status.disjoint = disjoint;
    status.full     = full;
    status.sp_zero  = (sp == '0);
    status.res_free = !res_valid || res_ready;
    status.phase    = top_ph;
  end

endmodule
